// ----- rtl/seeded_pattern_read_generator_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the seeded pattern read generator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SEEDED_PATTERN_READ_GENERATOR_TOP_MACROS_SVH
`define SEEDED_PATTERN_READ_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SPRG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define SPRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPRG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SPRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/sprg_pkg.sv -----
// ---------------------------------------------------------------------------
// sprg_pkg
// Constants and helpers shared by the seeded pattern read generator.
// ---------------------------------------------------------------------------
package sprg_pkg;

  // Golden-ratio multiplier used for the seed and for logical offsets.
  localparam logic [63:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

  // Register select, taken from paddr bit 3 (registers sit 8 bytes apart).
  localparam logic REG_ID_HIGH = 1'b0;
  localparam logic REG_ID_LOW  = 1'b1;

  // Bytes in one beat.
  localparam int unsigned BEAT_BYTES = 8;

  typedef logic [63:0] word_t;

  // One xorshift64 step: shifts 13 left, 7 right, 17 left.
  function automatic word_t xorshift64(input word_t s);
    word_t t;
    t = s ^ (s << 13);
    t = t ^ (t >> 7);
    t = t ^ (t << 17);
    return t;
  endfunction

endpackage

// ----- rtl/seeded_pattern_read_generator_top.sv -----
// ---------------------------------------------------------------------------
// seeded_pattern_read_generator_top
// Streams bytes of a seeded xorshift64 pattern store as 8-byte beats.
// ---------------------------------------------------------------------------
// After reset, and after every write of either identity register, the block
// forms the seed on its shared 32x32 multiplier (states S_SEED0 to S_SEED3)
// and then fills the pattern store, 2*PATTERN_BYTES/8 words, one word per
// cycle through the store's single write port; no read is taken meanwhile.
// A read then passes through set-up steps (index multiply, first and second
// word fetch) followed by one beat per cycle while the output is not
// stalled, ceil(length/8) beats with the length saturated at MAX_READ_BYTES.
// The one read port of the store sets the beat rate: each beat consumes
// exactly one new word.
// ---------------------------------------------------------------------------
`include "seeded_pattern_read_generator_top_macros.svh"

module seeded_pattern_read_generator_top
  import sprg_pkg::*;
#(
  parameter int PATTERN_BYTES  = 4096,
  parameter int MAX_READ_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Read requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] physical_offset,
  input  logic        has_logical,
  input  logic [63:0] logical_offset,
  input  logic [9:0]  read_len,
  // Data beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] data_word,
  output logic [3:0]  byte_count,
  output logic        last_beat
);

  localparam int IDX_W       = $clog2(PATTERN_BYTES);
  localparam int STORE_WORDS = (2 * PATTERN_BYTES) / BEAT_BYTES;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int LEN_W       = $clog2(MAX_READ_BYTES + 1);

  // Sequencer codes.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEED0  = 4'd1;
  localparam logic [3:0] S_SEED1  = 4'd2;
  localparam logic [3:0] S_SEED2  = 4'd3;
  localparam logic [3:0] S_SEED3  = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_IDX0   = 4'd6;
  localparam logic [3:0] S_IDX1   = 4'd7;
  localparam logic [3:0] S_LOAD0  = 4'd8;
  localparam logic [3:0] S_STREAM = 4'd9;

  logic [3:0]       state;
  logic [63:0]      disk_id_high;
  logic [63:0]      disk_id_low;
  logic [63:0]      prod;
  logic [63:0]      acc;
  word_t            gen;
  word_t            gen_next;
  logic [AW-1:0]    fill_addr;
  logic [IDX_W-1:0] phys;
  logic [IDX_W-1:0] logi;
  logic             has_log;
  logic [LEN_W-1:0] rem;
  logic [2:0]       offset;
  logic [AW-1:0]    rd_ptr;
  logic [63:0]      win_lo;

  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic             cfg_write;
  logic             in_fire;
  logic             beat_fire;
  logic [IDX_W-1:0] idx_sum;
  logic [AW-1:0]    first_word;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [63:0]      ram_rd_data;
  logic [127:0]     window;
  logic [63:0]      shifted;
  logic [63:0]      byte_mask;
  logic [3:0]       beat_bytes;
  logic             beat_last;

  // Configuration port: always ready, registers readable.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_ID_LOW) ? disk_id_low : disk_id_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_id_high <= '0;
      disk_id_low  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_ID_HIGH: disk_id_high <= pwdata;
        REG_ID_LOW:  disk_id_low  <= pwdata;
        default:     disk_id_high <= disk_id_high;
      endcase
    end
  end

  // Handshakes.
  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign beat_fire = (state == S_STREAM) && (!out_valid || !out_stall);

  // Shared multiplier: operand selection by sequencer step.
  always_comb begin
    unique case (state)
      S_SEED0: begin
        mul_a = disk_id_low[31:0];
        mul_b = GOLDEN_MULT[31:0];
      end
      S_SEED1: begin
        mul_a = disk_id_low[31:0];
        mul_b = GOLDEN_MULT[63:32];
      end
      S_SEED2: begin
        mul_a = disk_id_low[63:32];
        mul_b = GOLDEN_MULT[31:0];
      end
      default: begin
        mul_a = 32'(logi);
        mul_b = GOLDEN_MULT[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // Index of the first byte and its word.
  assign idx_sum    = phys + (has_log ? prod[IDX_W-1:0] : '0);
  assign first_word = AW'(idx_sum[IDX_W-1:3]);

  // Next generator value, written to the store during the fill.
  assign gen_next = xorshift64(gen);

  // Store read port.
  assign ram_rd_en   = (state == S_IDX1) || (state == S_LOAD0) || beat_fire;
  assign ram_rd_addr = (state == S_IDX1) ? first_word : rd_ptr;

  sprg_ram #(
    .WIDTH (64),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (state == S_FILL),
    .wr_addr (fill_addr),
    .wr_data (gen_next),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Beat assembly from the two-word window, bytes past the count cleared.
  assign window     = {ram_rd_data, win_lo};
  assign shifted    = 64'(window >> {offset, 3'b000});
  assign beat_last  = (rem <= LEN_W'(BEAT_BYTES));
  assign beat_bytes = beat_last ? rem[3:0] : 4'(BEAT_BYTES);

  always_comb begin
    for (int k = 0; k < BEAT_BYTES; k++) begin
      byte_mask[k*8 +: 8] = (4'(k) < beat_bytes) ? 8'hFF : 8'h00;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SEED0;
      fill_addr <= '0;
    end else if (cfg_write) begin
      state     <= S_SEED0;
      fill_addr <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && (read_len != '0)) begin
            state <= S_IDX0;
          end
        end
        S_SEED0: state <= S_SEED1;
        S_SEED1: state <= S_SEED2;
        S_SEED2: state <= S_SEED3;
        S_SEED3: begin
          state     <= S_FILL;
          fill_addr <= '0;
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDX0:  state <= S_IDX1;
        S_IDX1:  state <= S_LOAD0;
        S_LOAD0: state <= S_STREAM;
        S_STREAM: begin
          if (beat_fire && beat_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Seed accumulation and generator state.
  always_ff @(posedge clk) begin
    unique case (state)
      S_SEED1: acc <= prod;
      S_SEED2: acc[63:32] <= acc[63:32] + prod[31:0];
      S_SEED3: gen <= disk_id_high ^ {acc[63:32] + prod[31:0], acc[31:0]};
      S_FILL:  gen <= gen_next;
      default: acc <= acc;
    endcase
  end

  // Request capture; the length saturates at the largest read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      phys    <= physical_offset[IDX_W-1:0];
      logi    <= logical_offset[IDX_W-1:0];
      has_log <= has_logical;
      if (32'(read_len) > 32'(MAX_READ_BYTES)) begin
        rem <= LEN_W'(MAX_READ_BYTES);
      end else begin
        rem <= LEN_W'(read_len);
      end
    end else if (beat_fire) begin
      rem <= rem - LEN_W'(beat_bytes);
    end
  end

  // Word pointer and window low word.
  always_ff @(posedge clk) begin
    if (state == S_IDX1) begin
      offset <= idx_sum[2:0];
      rd_ptr <= first_word + AW'(1);
    end else if (state == S_LOAD0) begin
      win_lo <= ram_rd_data;
      rd_ptr <= rd_ptr + AW'(1);
    end else if (beat_fire) begin
      win_lo <= ram_rd_data;
      rd_ptr <= rd_ptr + AW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_fire) begin
      data_word  <= shifted & byte_mask;
      byte_count <= beat_bytes;
      last_beat  <= beat_last;
    end
  end

  // Checks.
  `SPRG_ASSERT_IMPLY(a_count_range, clk, rst, out_valid,
    byte_count != 4'd0 && byte_count <= 4'd8, "beat byte count out of range")
  `SPRG_ASSERT_IMPLY(a_full_mid_beat, clk, rst, out_valid && !last_beat,
    byte_count == 4'd8, "beat before the last is not full")
  `SPRG_ASSERT_IMPLY(a_beat_from_stream, clk, rst, $rose(out_valid),
    $past(state == S_STREAM), "beat appeared outside streaming")
  `SPRG_ASSERT_NEXT(a_fill_ends, clk, rst,
    state == S_FILL && fill_addr == '1 && !cfg_write,
    state == S_IDLE && fill_addr == '0, "fill did not end at the last word")

endmodule

// ----- rtl/sprg_ram.sv -----
// ---------------------------------------------------------------------------
// sprg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module sprg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// Testbench for seeded_pattern_read_generator_top
// Drives read requests and identity writes, and checks every data beat
// against a seeded xorshift64 store model held here or typed zero results.
// ---------------------------------------------------------------------------
module tb_top
  import sprg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PATTERN_BYTES  = 4096;
  localparam int unsigned MAX_READ_BYTES = 512;
  localparam int unsigned STORE_WORDS    = (2 * PATTERN_BYTES) / 8;
  localparam int unsigned RANDOM_PHASES  = 4;
  localparam int unsigned PHASE_READS    = 40;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT    = 12000;

  // Kinds of row in the directed table.
  typedef enum logic [1:0] {
    ROW_ZERO_STORE,  // read from the all-zero store left by reset, typed result
    ROW_READ,        // read checked against the store model
    ROW_SET_ID       // rewrite both identity halves
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] phys;
    logic        has_log;
    logic [63:0] logical;
    logic [9:0]  len;
    logic [63:0] id_hi;
    logic [63:0] id_lo;
    logic [6:0]  beats;
    logic [3:0]  last_bytes;
  } stim_row_t;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } beat_t;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ZERO = 64'h0;

  localparam int unsigned DIRECTED_ROWS = 23;
  localparam stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    // Reset identity gives a zero seed, so every pattern byte is zero.
    '{ROW_ZERO_STORE, ZERO,    1'b0, ZERO,    10'd0,    ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_ZERO_STORE, ZERO,    1'b0, ZERO,    10'd1,    ZERO, ZERO, 7'd1,  4'd1},
    '{ROW_ZERO_STORE, ZERO,    1'b0, ZERO,    10'd8,    ZERO, ZERO, 7'd1,  4'd8},
    '{ROW_ZERO_STORE, 64'd3,   1'b0, ZERO,    10'd9,    ZERO, ZERO, 7'd2,  4'd1},
    '{ROW_ZERO_STORE, ONES,    1'b1, ONES,    10'd512,  ZERO, ZERO, 7'd64, 4'd8},
    '{ROW_ZERO_STORE, 64'd4095, 1'b0, ZERO,   10'd1023, ZERO, ZERO, 7'd64, 4'd8},
    '{ROW_SET_ID,     ZERO,    1'b0, ZERO,    10'd0,    ZERO, 64'd1, 7'd0, 4'd0},
    '{ROW_READ,       ZERO,    1'b0, ZERO,    10'd1,    ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       ONES,    1'b0, ZERO,    10'd512,  ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       64'd4095, 1'b1, ZERO,   10'd513,  ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       ZERO,    1'b1, ONES,    10'd17,   ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       ZERO,    1'b1, 64'd1,   10'd8,    ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       64'd7,   1'b0, ZERO,    10'd15,   ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       ZERO,    1'b1, 64'h5555_5555_5555_5555, 10'd0, ZERO, ZERO, 7'd0, 4'd0},
    '{ROW_READ,       64'h8000_0000_0000_0000, 1'b0, ZERO, 10'd1023, ZERO, ZERO, 7'd0, 4'd0},
    '{ROW_SET_ID,     ZERO,    1'b0, ZERO,    10'd0,    ONES, ONES, 7'd0,  4'd0},
    '{ROW_READ,       64'h123, 1'b0, ZERO,    10'd100,  ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h5555_5555_5555_5555, 10'd64,
      ZERO, ZERO, 7'd0, 4'd0},
    '{ROW_READ,       ZERO,    1'b0, ZERO,    10'd0,    ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_READ,       64'd4088, 1'b0, ZERO,   10'd16,   ZERO, ZERO, 7'd0,  4'd0},
    '{ROW_SET_ID,     ZERO,    1'b0, ZERO,    10'd0,
      64'h0123_4567_89AB_CDEF, ZERO, 7'd0, 4'd0},
    '{ROW_READ,       64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000, 10'd511,
      ZERO, ZERO, 7'd0, 4'd0},
    '{ROW_READ,       64'd4095, 1'b0, ZERO,   10'd1,    ZERO, ZERO, 7'd0,  4'd0}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] physical_offset;
  logic        has_logical;
  logic [63:0] logical_offset;
  logic [9:0]  read_len;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_beat;

  // Model of the block: identity registers and the pattern store they seed.
  logic [63:0] id_high;
  logic [63:0] id_low;
  logic [63:0] pattern_words [0:STORE_WORDS-1];
  beat_t       pending_beats [$];

  int unsigned mismatches;
  int unsigned reads_sent;
  int unsigned beats_checked;
  int unsigned id_writes;
  int unsigned empty_reads;
  int unsigned clipped_reads;
  int unsigned stall_cycles;
  bit          send_quiet;
  bit          recv_quiet;

  seeded_pattern_read_generator_top DUT (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .physical_offset (physical_offset),
    .has_logical     (has_logical),
    .logical_offset  (logical_offset),
    .read_len        (read_len),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .data_word       (data_word),
    .byte_count      (byte_count),
    .last_beat       (last_beat)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rebuild the pattern store from the current identity.
  function automatic void reseed_pattern();
    logic [63:0] s;
    s = id_high ^ (id_low * GOLDEN_MULT);
    for (int unsigned w = 0; w < STORE_WORDS; w++) begin
      s = s ^ (s << 13);
      s = s ^ (s >> 7);
      s = s ^ (s << 17);
      pattern_words[w] = s;
    end
  endfunction

  // Work out the beats that one read produces and queue them.
  function automatic void predict_read_beats(input logic [63:0] phys, input logic has_log,
                                             input logic [63:0] logical,
                                             input logic [9:0] len);
    logic [63:0] sum;
    int unsigned first;
    int unsigned total;
    int unsigned done;
    int unsigned n;
    int unsigned pos;
    beat_t       b;
    total = (len > MAX_READ_BYTES) ? MAX_READ_BYTES : len;
    sum = phys;
    if (has_log) begin
      sum = sum + logical * GOLDEN_MULT;
    end
    first = 32'(sum % PATTERN_BYTES);
    done = 0;
    while (done < total) begin
      n = (total - done > 8) ? 8 : total - done;
      b.data = '0;
      for (int unsigned k = 0; k < n; k++) begin
        pos = first + done + k;
        b.data[8*k +: 8] = pattern_words[(pos / 8) % STORE_WORDS][8*(pos % 8) +: 8];
      end
      done += n;
      b.count = 4'(n);
      b.last = (done == total);
      pending_beats.push_back(b);
    end
  endfunction

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  // One configuration access: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input logic sel, input logic [63:0] wdata,
                            output logic [63:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending, wait for every expected beat, then let zero-length reads settle.
  task automatic drain_reads();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one identity half, refresh the model and read the register back.
  task automatic write_identity(input logic sel, input logic [63:0] value);
    logic [63:0] rd;
    apb_access(1'b1, sel, value, rd);
    if (sel == REG_ID_HIGH) begin
      id_high = value;
    end else begin
      id_low = value;
    end
    reseed_pattern();
    id_writes++;
    apb_access(1'b0, sel, ZERO, rd);
    if (rd !== value) begin
      $display("%0t: identity readback, reg %0d: expected %h, actual %h",
               $time, sel, value, rd);
      mismatches++;
    end
  endtask

  // Present one read request and queue its expected beats once accepted.
  // Entered and left at a falling edge.
  task automatic send_read(input stim_row_t r);
    int unsigned gap;
    beat_t       b;
    if ($urandom_range(0, 15) == 0) begin
      send_quiet = !send_quiet;
    end
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    physical_offset <= r.phys;
    has_logical     <= r.has_log;
    logical_offset  <= r.logical;
    read_len        <= r.len;
    do @(posedge clk); while (in_stall);
    if (r.kind == ROW_ZERO_STORE) begin
      for (int unsigned i = 0; i < r.beats; i++) begin
        b.data  = ZERO;
        b.count = (i == r.beats - 1) ? r.last_bytes : 4'd8;
        b.last  = (i == r.beats - 1);
        pending_beats.push_back(b);
      end
    end else begin
      predict_read_beats(r.phys, r.has_log, r.logical, r.len);
    end
    reads_sent++;
    if (r.len == 0) begin
      empty_reads++;
    end
    if (r.len > MAX_READ_BYTES) begin
      clipped_reads++;
    end
    @(negedge clk);
  endtask

  // Receiver: a random stall before each beat, with quiet stretches.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) begin
        recv_quiet = !recv_quiet;
      end
      n = draw_wait(recv_quiet);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Beat checker.
  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual data %h count %0d last %0b",
                 $time, data_word, byte_count, last_beat);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (data_word !== want.data) begin
          $display("%0t: data_word: expected %h, actual %h", $time, want.data, data_word);
          mismatches++;
        end
        if (byte_count !== want.count) begin
          $display("%0t: byte_count: expected %0d, actual %0d",
                   $time, want.count, byte_count);
          mismatches++;
        end
        if (last_beat !== want.last) begin
          $display("%0t: last_beat: expected %0b, actual %0b", $time, want.last, last_beat);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("seeded_pattern_read_generator_top: mismatch");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    stim_row_t   r;
    int unsigned pick;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    physical_offset = '0;
    has_logical     = 1'b0;
    logical_offset  = '0;
    read_len        = '0;
    mismatches      = 0;
    reads_sent      = 0;
    beats_checked   = 0;
    id_writes       = 0;
    empty_reads     = 0;
    clipped_reads   = 0;
    send_quiet      = 1'b0;
    id_high         = '0;
    id_low          = '0;
    reseed_pattern();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
      r = directed_rows[i];
      if (r.kind == ROW_SET_ID) begin
        drain_reads();
        write_identity(REG_ID_HIGH, r.id_hi);
        write_identity(REG_ID_LOW, r.id_lo);
      end else begin
        send_read(r);
      end
    end

    // Random phases, each under a new identity (phases 1 and 2 rewrite one half only).
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_reads();
      r.id_hi = {$urandom, $urandom};
      r.id_lo = {$urandom, $urandom};
      if (ph != 2) begin
        write_identity(REG_ID_HIGH, r.id_hi);
      end
      if (ph != 1) begin
        write_identity(REG_ID_LOW, r.id_lo);
      end
      for (int unsigned i = 0; i < PHASE_READS; i++) begin
        // Once, let everything in flight come out before carrying on.
        if (ph == 0 && i == PHASE_READS / 2) begin
          drain_reads();
        end
        r.kind    = ROW_READ;
        r.phys    = ($urandom_range(0, 7) == 0) ? ONES : {$urandom, $urandom};
        r.has_log = 1'($urandom_range(0, 1));
        r.logical = ($urandom_range(0, 7) == 0) ? ONES : {$urandom, $urandom};
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          r.len = 10'd0;
        end else if (pick == 1) begin
          r.len = 10'($urandom_range(MAX_READ_BYTES + 1, 1023));
        end else if (pick == 2) begin
          r.len = 10'($urandom_range(MAX_READ_BYTES - 8, MAX_READ_BYTES));
        end else if (pick < 7) begin
          r.len = 10'($urandom_range(1, 8));
        end else begin
          r.len = 10'($urandom_range(1, 64));
        end
        send_read(r);
      end
    end

    // Finish once every beat has arrived and the block has had time to settle.
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d reads (%0d of zero length, %0d clipped), %0d beats checked,",
             reads_sent, empty_reads, clipped_reads, beats_checked);
    $display("and %0d identity writes with readback.", id_writes);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("seeded_pattern_read_generator_top: match");
    end else begin
      $display("seeded_pattern_read_generator_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sprg_pkg.sv
rtl/sprg_ram.sv
rtl/seeded_pattern_read_generator_top.sv
tb/tb_top.sv
